[rtl/core/iais_pkg.sv]
// ----------------------------------------------------------------------------
// iais_pkg: shared types for the indexed array unit
// Operation codes, status codes, the per-cell command and CSR indexes.
// ----------------------------------------------------------------------------
package iais_pkg;

   // operation requested by an input beat
   typedef enum logic [3:0] {
      FN_SEARCH     = 4'd0,
      FN_UPDATE     = 4'd1,
      FN_READ       = 4'd2,
      FN_INSERT     = 4'd3,
      FN_REMOVE     = 4'd4,
      FN_PUSH_FRONT = 4'd5,
      FN_PUSH_BACK  = 4'd6,
      FN_POP_FRONT  = 4'd7,
      FN_POP_BACK   = 4'd8
   } iais_func_type;

   // result status, first failing check wins
   typedef enum logic [2:0] {
      STS_OK    = 3'd0,
      STS_RANGE = 3'd1,
      STS_FULL  = 3'd2,
      STS_EMPTY = 3'd3,
      STS_INDEX = 3'd4
   } iais_status_type;

   // command broadcast to the row of cells
   typedef enum logic [1:0] {
      OP_HOLD   = 2'd0,
      OP_WRITE  = 2'd1,
      OP_INSERT = 2'd2,
      OP_REMOVE = 2'd3
   } iais_op_type;

   // config register indexes
   localparam logic CSR_VALUE_MIN = 1'b0;
   localparam logic CSR_VALUE_MAX = 1'b1;

endpackage

[rtl/core/iais_req_if.sv]
// ----------------------------------------------------------------------------
// iais_req_if: request channel
// Valid/ready channel carrying one operation beat.
// ----------------------------------------------------------------------------
interface iais_req_if #(
   parameter int VALUE_BITS = 16
);
   logic                         valid;
   logic                         ready;
   logic [3:0]                   func;
   logic [4:0]                   index;
   logic signed [VALUE_BITS-1:0] value;

   modport source (output valid, output func, output index, output value, input ready);
   modport sink   (input valid, input func, input index, input value, output ready);
endinterface

[rtl/core/iais_rsp_if.sv]
// ----------------------------------------------------------------------------
// iais_rsp_if: response channel
// Valid/ready channel carrying one result beat.
// ----------------------------------------------------------------------------
interface iais_rsp_if #(
   parameter int VALUE_BITS = 16
);
   logic                         valid;
   logic                         ready;
   logic [2:0]                   status;
   logic                         found;
   logic [3:0]                   hit_index;
   logic signed [VALUE_BITS-1:0] read_value;
   logic [4:0]                   count;

   modport source (output valid, output status, output found, output hit_index,
                   output read_value, output count, input ready);
   modport sink   (input valid, input status, input found, input hit_index,
                   input read_value, input count, output ready);
endinterface

[rtl/core/iais_cell.sv]
// ----------------------------------------------------------------------------
// iais_cell: one array entry
// Holds one value, takes a neighbor's value on insert/remove shifts and
// compares its value against the search key.
// ----------------------------------------------------------------------------
module iais_cell #(
   parameter int CELL_INDEX = 0,
   parameter int VALUE_BITS = 16,
   parameter int POS_BITS   = 5
) (
   input  logic                         clock,
   input  iais_pkg::iais_op_type        op,
   input  logic [POS_BITS-1:0]          pos,
   input  logic [POS_BITS-1:0]          count,
   input  logic signed [VALUE_BITS-1:0] key,
   input  logic signed [VALUE_BITS-1:0] left_data,
   input  logic signed [VALUE_BITS-1:0] right_data,
   output logic signed [VALUE_BITS-1:0] data,
   output logic                         match
);
   import iais_pkg::*;

   localparam logic [POS_BITS-1:0] MY_POS = POS_BITS'(CELL_INDEX);

   logic signed [VALUE_BITS-1:0] elem_ff;
   logic signed [VALUE_BITS-1:0] elem_in;

   // next value from command and position
   always_comb begin
      elem_in = elem_ff;
      case (op)
         OP_WRITE: begin
            if (MY_POS == pos) elem_in = key;
         end
         OP_INSERT: begin
            if (MY_POS == pos) elem_in = key;
            else if (MY_POS > pos) elem_in = left_data;
         end
         OP_REMOVE: begin
            if (MY_POS >= pos) elem_in = right_data;
         end
         default: elem_in = elem_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      elem_ff <= elem_in;
   end

   assign data  = elem_ff;
   assign match = (MY_POS < count) && (elem_ff == key);

endmodule

[rtl/core/iais_row.sv]
// ----------------------------------------------------------------------------
// iais_row: row of cells
// Chains the cells, finds the first matching entry and reads one entry.
// ----------------------------------------------------------------------------
module iais_row #(
   parameter int MAX_ELEMENTS = 16,
   parameter int VALUE_BITS   = 16,
   parameter int POS_BITS     = 5,
   parameter int IDX_BITS     = 4
) (
   input  logic                         clock,
   input  iais_pkg::iais_op_type        op,
   input  logic [POS_BITS-1:0]          pos,
   input  logic [POS_BITS-1:0]          count,
   input  logic signed [VALUE_BITS-1:0] key,
   input  logic [IDX_BITS-1:0]          rd_pos,
   output logic signed [VALUE_BITS-1:0] rd_data,
   output logic                         hit,
   output logic [POS_BITS-1:0]          hit_pos
);
   import iais_pkg::*;

   logic signed [VALUE_BITS-1:0] cell_data [MAX_ELEMENTS];
   logic [MAX_ELEMENTS-1:0]      cell_match;

   // cells with neighbor links; end cells loop back to themselves
   for (genvar i = 0; i < MAX_ELEMENTS; i++) begin : g_cell
      logic signed [VALUE_BITS-1:0] left_w;
      logic signed [VALUE_BITS-1:0] right_w;

      if (i == 0) begin : g_first
         assign left_w = cell_data[i];
      end else begin : g_left
         assign left_w = cell_data[i-1];
      end
      if (i == MAX_ELEMENTS - 1) begin : g_last
         assign right_w = cell_data[i];
      end else begin : g_right
         assign right_w = cell_data[i+1];
      end

      iais_cell #(
         .CELL_INDEX (i),
         .VALUE_BITS (VALUE_BITS),
         .POS_BITS   (POS_BITS)
      ) u_cell (
         .clock      (clock),
         .op         (op),
         .pos        (pos),
         .count      (count),
         .key        (key),
         .left_data  (left_w),
         .right_data (right_w),
         .data       (cell_data[i]),
         .match      (cell_match[i])
      );
   end

   // first matching cell wins
   always_comb begin
      hit     = 1'b0;
      hit_pos = '0;
      for (int i = MAX_ELEMENTS - 1; i >= 0; i--) begin
         if (cell_match[i]) begin
            hit     = 1'b1;
            hit_pos = POS_BITS'(i);
         end
      end
   end

   // indexed read
   assign rd_data = cell_data[rd_pos];

endmodule

[rtl/core/indexed_array_insert_remove_search_unit.sv]
// A result beat is presented the cycle after its request beat is taken.
// One operation per cycle unless a result stalls; every cell shifts or compares.
// A waiting result does not block the next request while the sink takes it.
// Reset clears the entry count and the result valid, and sets the value limits
// to the full 16-bit signed range; stored entries are undefined until written.
// ----------------------------------------------------------------------------
// indexed_array_insert_remove_search_unit: bounded ordered array
// Insert, remove, update, read and search over a row of shifting cells.
// ----------------------------------------------------------------------------
module indexed_array_insert_remove_search_unit #(
   parameter int MAX_ELEMENTS = 16,
   parameter int VALUE_BITS   = 16
) (
   input  logic        clock,
   input  logic        reset,
   iais_req_if.sink    req,
   iais_rsp_if.source  rsp,
   input  logic        csr_wr_en,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata
);
   import iais_pkg::*;

   localparam int CNT_BITS = $clog2(MAX_ELEMENTS + 1);
   localparam int POS_BITS = (CNT_BITS > 5) ? CNT_BITS : 5;
   localparam int IDX_BITS = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
   localparam int RNG_BITS = (VALUE_BITS > 16) ? VALUE_BITS : 16;
   localparam logic [POS_BITS-1:0] MAX_POS = POS_BITS'(MAX_ELEMENTS);

   // config registers
   logic signed [15:0] value_min_ff;
   logic signed [15:0] value_max_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         value_min_ff <= 16'sh8000;
         value_max_ff <= 16'sh7fff;
      end else if (csr_wr_en) begin
         if (csr_index == CSR_VALUE_MIN) value_min_ff <= csr_wdata;
         if (csr_index == CSR_VALUE_MAX) value_max_ff <= csr_wdata;
      end
   end

   // state and result registers
   logic [CNT_BITS-1:0]          count_ff;
   logic [CNT_BITS-1:0]          count_in;
   logic                         rsp_valid_ff;
   logic [2:0]                   status_ff;
   logic                         found_ff;
   logic [3:0]                   hit_index_ff;
   logic signed [VALUE_BITS-1:0] read_value_ff;
   logic [4:0]                   count_out_ff;

   logic accept;
   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign accept    = req.valid && req.ready;

   // operand views
   iais_func_type                fn;
   logic [POS_BITS-1:0]          cnt_x;
   logic [POS_BITS-1:0]          k_x;
   logic signed [RNG_BITS-1:0]   key_x;
   logic signed [RNG_BITS-1:0]   min_x;
   logic signed [RNG_BITS-1:0]   max_x;
   logic                         in_range;
   logic                         empty;
   logic                         full;

   assign fn       = iais_func_type'(req.func);
   assign cnt_x    = POS_BITS'(count_ff);
   assign k_x      = POS_BITS'(req.index);
   assign key_x    = RNG_BITS'(req.value);
   assign min_x    = RNG_BITS'(value_min_ff);
   assign max_x    = RNG_BITS'(value_max_ff);
   assign in_range = (key_x >= min_x) && (key_x <= max_x);
   assign empty    = (count_ff == '0);
   assign full     = (cnt_x >= MAX_POS);

   // row interface
   iais_op_type                  op_dec;
   iais_op_type                  row_op;
   logic [POS_BITS-1:0]          pos_dec;
   logic signed [VALUE_BITS-1:0] rd_data;
   logic                         row_hit;
   logic [POS_BITS-1:0]          row_hit_pos;

   assign row_op = accept ? op_dec : OP_HOLD;

   iais_row #(
      .MAX_ELEMENTS (MAX_ELEMENTS),
      .VALUE_BITS   (VALUE_BITS),
      .POS_BITS     (POS_BITS),
      .IDX_BITS     (IDX_BITS)
   ) u_row (
      .clock   (clock),
      .op      (row_op),
      .pos     (pos_dec),
      .count   (cnt_x),
      .key     (req.value),
      .rd_pos  (k_x[IDX_BITS-1:0]),
      .rd_data (rd_data),
      .hit     (row_hit),
      .hit_pos (row_hit_pos)
   );

   // operation decode with ordered checks
   iais_status_type              sts_dec;
   logic                         found_dec;
   logic [POS_BITS-1:0]          hit_dec;
   logic signed [VALUE_BITS-1:0] rd_dec;

   always_comb begin
      op_dec    = OP_HOLD;
      pos_dec   = k_x;
      sts_dec   = STS_OK;
      found_dec = 1'b0;
      hit_dec   = '0;
      rd_dec    = '0;
      count_in  = count_ff;
      unique case (fn) inside
         FN_SEARCH: begin
            if (!in_range) sts_dec = STS_RANGE;
            else begin
               found_dec = row_hit;
               hit_dec   = row_hit_pos;
            end
         end
         FN_UPDATE: begin
            if (empty) sts_dec = STS_EMPTY;
            else if (k_x >= cnt_x) sts_dec = STS_INDEX;
            else if (!in_range) sts_dec = STS_RANGE;
            else op_dec = OP_WRITE;
         end
         FN_READ: begin
            if (empty) sts_dec = STS_EMPTY;
            else if (k_x >= cnt_x) sts_dec = STS_INDEX;
            else rd_dec = rd_data;
         end
         FN_INSERT, FN_PUSH_FRONT, FN_PUSH_BACK: begin
            if (fn == FN_PUSH_FRONT) pos_dec = '0;
            else if (fn == FN_PUSH_BACK) pos_dec = cnt_x;
            if (!in_range) sts_dec = STS_RANGE;
            else if (full) sts_dec = STS_FULL;
            else if (fn == FN_INSERT && k_x > cnt_x) sts_dec = STS_INDEX;
            else begin
               op_dec   = OP_INSERT;
               count_in = count_ff + 1'b1;
            end
         end
         FN_REMOVE, FN_POP_FRONT, FN_POP_BACK: begin
            if (fn == FN_POP_FRONT) pos_dec = '0;
            else if (fn == FN_POP_BACK) pos_dec = cnt_x - 1'b1;
            if (empty) begin
               // popping an empty array is a quiet no-op
               if (fn == FN_REMOVE) sts_dec = STS_EMPTY;
            end else if (fn == FN_REMOVE && k_x >= cnt_x) sts_dec = STS_INDEX;
            else begin
               op_dec   = OP_REMOVE;
               count_in = count_ff - 1'b1;
            end
         end
         default: op_dec = OP_HOLD;
      endcase
   end

   logic [POS_BITS-1:0] count_in_x;
   assign count_in_x = POS_BITS'(count_in);

   // count and valid
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            count_ff     <= count_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff     <= sts_dec;
         found_ff      <= found_dec;
         hit_index_ff  <= hit_dec[3:0];
         read_value_ff <= rd_dec;
         count_out_ff  <= count_in_x[4:0];
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.status     = status_ff;
   assign rsp.found      = found_ff;
   assign rsp.hit_index  = hit_index_ff;
   assign rsp.read_value = read_value_ff;
   assign rsp.count      = count_out_ff;

endmodule

[bench/array_result_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// array_result_checker: scoreboard for the indexed array unit
// Watches the request, result and limit-register ports, keeps a shadow copy
// of the array and its limits, predicts each result beat and compares it
// field by field against what the unit returns.
// ----------------------------------------------------------------------------
module array_result_checker #(
   parameter int DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   iais_req_if         req_mon,
   iais_rsp_if         rsp_mon,
   input  logic        csr_wr_en,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata,
   output int          mismatch_count,
   output int          pending_results,
   output int          checked_count
);
   import iais_pkg::*;

   // one predicted result beat
   typedef struct {
      iais_status_type    status;
      logic               found;
      logic [3:0]         hit_index;
      logic signed [15:0] read_value;
      logic [4:0]         count;
   } array_result_type;

   // shadow array, fill level and value limits
   logic signed [15:0] cells [DEPTH];
   int                 fill;
   logic signed [15:0] limit_lo;
   logic signed [15:0] limit_hi;
   array_result_type   pending_outcomes [$];

   initial begin
      mismatch_count  = 0;
      pending_results = 0;
      checked_count   = 0;
   end

   task automatic report_mismatch(input string what, input logic signed [31:0] got,
                                  input logic signed [31:0] want);
      mismatch_count++;
      $display("checker: result beat %0d: %s got %0d want %0d",
               checked_count, what, got, want);
   endtask

   // apply one operation to the shadow array and return its result beat
   function automatic array_result_type apply_array_op(input logic [3:0] fn,
                                                       input logic [4:0] pos,
                                                       input logic signed [15:0] val);
      array_result_type res;
      int               k;
      logic             fits;
      res.status     = STS_OK;
      res.found      = 1'b0;
      res.hit_index  = '0;
      res.read_value = '0;
      k              = pos;
      fits           = (val >= limit_lo) && (val <= limit_hi);
      case (iais_func_type'(fn))
         FN_SEARCH: begin
            if (!fits) begin
               res.status = STS_RANGE;
            end else begin
               // walk down so the lowest matching index wins
               for (int i = fill - 1; i >= 0; i--) begin
                  if (cells[i] == val) begin
                     res.found     = 1'b1;
                     res.hit_index = 4'(i);
                  end
               end
            end
         end
         FN_UPDATE: begin
            if (fill == 0)      res.status = STS_EMPTY;
            else if (k >= fill) res.status = STS_INDEX;
            else if (!fits)     res.status = STS_RANGE;
            else                cells[k] = val;
         end
         FN_READ: begin
            if (fill == 0)      res.status = STS_EMPTY;
            else if (k >= fill) res.status = STS_INDEX;
            else                res.read_value = cells[k];
         end
         FN_INSERT, FN_PUSH_FRONT, FN_PUSH_BACK: begin
            if (!fits) begin
               res.status = STS_RANGE;
            end else if (fill >= DEPTH) begin
               res.status = STS_FULL;
            end else begin
               if (fn == FN_PUSH_FRONT)     k = 0;
               else if (fn == FN_PUSH_BACK) k = fill;
               if (k > fill) begin
                  res.status = STS_INDEX;
               end else begin
                  // entries at and above k move up one cell
                  for (int i = fill; i > k; i--) cells[i] = cells[i-1];
                  cells[k] = val;
                  fill++;
               end
            end
         end
         FN_REMOVE, FN_POP_FRONT, FN_POP_BACK: begin
            if (fill == 0) begin
               // popping an empty array is not an error
               if (fn == FN_REMOVE) res.status = STS_EMPTY;
            end else begin
               if (fn == FN_POP_FRONT)     k = 0;
               else if (fn == FN_POP_BACK) k = fill - 1;
               if (k >= fill) begin
                  res.status = STS_INDEX;
               end else begin
                  // entries above k move down one cell
                  for (int i = k; i + 1 < fill; i++) cells[i] = cells[i+1];
                  fill--;
               end
            end
         end
         default: ;
      endcase
      res.count = 5'(fill);
      return res;
   endfunction

   // result beats are compared before the request beat of the same edge is added
   always @(posedge clock) begin : monitor
      array_result_type want;
      if (reset) begin
         fill     = 0;
         limit_lo = 16'sh8000;
         limit_hi = 16'sh7FFF;
         for (int i = 0; i < DEPTH; i++) cells[i] = '0;
         pending_outcomes.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (pending_outcomes.size() == 0) begin
               report_mismatch("unexpected beat, count", rsp_mon.count, 0);
            end else begin
               want = pending_outcomes.pop_front();
               if (rsp_mon.status !== want.status)
                  report_mismatch("status", rsp_mon.status, want.status);
               if (rsp_mon.found !== want.found)
                  report_mismatch("found", rsp_mon.found, want.found);
               if (rsp_mon.hit_index !== want.hit_index)
                  report_mismatch("hit_index", rsp_mon.hit_index, want.hit_index);
               if (rsp_mon.read_value !== want.read_value)
                  report_mismatch("read_value", rsp_mon.read_value, want.read_value);
               if (rsp_mon.count !== want.count)
                  report_mismatch("count", rsp_mon.count, want.count);
            end
            checked_count++;
         end
         if (req_mon.valid && req_mon.ready)
            pending_outcomes.push_back(apply_array_op(req_mon.func, req_mon.index,
                                                      req_mon.value));
         if (csr_wr_en) begin
            if (csr_index == CSR_VALUE_MIN) limit_lo = csr_wdata;
            else                            limit_hi = csr_wdata;
         end
      end
      pending_results = pending_outcomes.size();
   end

endmodule

[bench/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the indexed array unit
// Drives directed and random operation beats under varying idle patterns and
// value limits, with a long result hold-off and drain pauses; a separate
// checker predicts and compares every result beat.
// ----------------------------------------------------------------------------
module tb_top;
   import iais_pkg::*;

   localparam int CYCLE_LIMIT      = 200000;
   localparam int RANDOM_PER_PHASE = 100;
   localparam int LONG_HOLD        = 300;
   localparam int POOL_SIZE        = 8;

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_wr_en;
   logic        csr_index;
   logic [15:0] csr_wdata;

   int mismatch_count;
   int pending_results;
   int checked_count;
   int cycle_count    = 0;
   int send_idle_pct  = 0;
   int recv_idle_pct  = 0;
   int hold_requests  = 0;
   int items_sent     = 0;
   int limit_writes   = 0;

   logic signed [15:0] cfg_lo = 16'sh8000;
   logic signed [15:0] cfg_hi = 16'sh7FFF;
   logic signed [15:0] value_pool [POOL_SIZE];

   iais_req_if #(.VALUE_BITS(16)) req_if ();
   iais_rsp_if #(.VALUE_BITS(16)) rsp_if ();

   indexed_array_insert_remove_search_unit #(
      .MAX_ELEMENTS (16),
      .VALUE_BITS   (16)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_if),
      .rsp       (rsp_if),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   array_result_checker #(.DEPTH(16)) u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_if),
      .rsp_mon         (rsp_if),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .mismatch_count  (mismatch_count),
      .pending_results (pending_results),
      .checked_count   (checked_count)
   );

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // result side: random stalls, plus a long hold-off on request
   initial begin : result_sink
      int hold_left;
      int hold_seen;
      hold_left       = 0;
      hold_seen       = 0;
      rsp_if.ready    = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_seen != hold_requests) begin
            hold_seen = hold_requests;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // a value inside the current limits, or anything when they are inverted
   function automatic logic signed [15:0] in_range_value();
      int span;
      if (cfg_lo > cfg_hi) return 16'($urandom());
      span = int'(cfg_hi) - int'(cfg_lo);
      return 16'(int'(cfg_lo) + int'($urandom_range(span)));
   endfunction

   // mostly pool values so searches hit, some edges and raw noise
   function automatic logic signed [15:0] pick_value();
      int roll;
      roll = $urandom_range(99);
      if (roll < 50)      return value_pool[$urandom_range(POOL_SIZE - 1)];
      else if (roll < 75) return in_range_value();
      else if (roll < 79) return cfg_lo;
      else if (roll < 83) return cfg_hi;
      else if (roll < 86) return cfg_lo - 16'sd1;
      else if (roll < 89) return cfg_hi + 16'sd1;
      else                return 16'($urandom());
   endfunction

   // offer one request beat, with random idle cycles ahead of it
   task automatic send_beat(input logic [3:0] fn, input logic [4:0] pos,
                            input logic signed [15:0] val);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.func  <= fn;
      req_if.index <= pos;
      req_if.value <= val;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      items_sent++;
      @(negedge clock);
   endtask

   // stop offering and wait until every result beat is back
   task automatic wait_for_drain();
      req_if.valid <= 1'b0;
      @(negedge clock);
      while (pending_results != 0) @(negedge clock);
      repeat (2) @(negedge clock);
   endtask

   // program both limits while idle, then refresh the value pool
   task automatic write_limits(input logic signed [15:0] lo, input logic signed [15:0] hi);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_VALUE_MIN;
      csr_wdata <= lo;
      @(negedge clock);
      csr_index <= CSR_VALUE_MAX;
      csr_wdata <= hi;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      @(negedge clock);
      cfg_lo = lo;
      cfg_hi = hi;
      limit_writes++;
      for (int j = 0; j < POOL_SIZE; j++) value_pool[j] = in_range_value();
   endtask

   // random operations, swinging between filling and draining the array
   task automatic random_ops(input int n);
      int         roll;
      logic [3:0] fn;
      logic [4:0] pos;
      logic       filling;
      for (int i = 0; i < n; i++) begin
         filling = ((i / 40) % 2) == 0;
         roll    = $urandom_range(99);
         if (roll < 4)       fn = 4'(9 + $urandom_range(6));
         else if (roll < 16) fn = FN_SEARCH;
         else if (roll < 24) fn = FN_UPDATE;
         else if (roll < 32) fn = FN_READ;
         else if ((filling && roll < 80) || (!filling && roll < 50)) begin
            case ($urandom_range(2))
               0:       fn = FN_INSERT;
               1:       fn = FN_PUSH_FRONT;
               default: fn = FN_PUSH_BACK;
            endcase
         end else begin
            case ($urandom_range(2))
               0:       fn = FN_REMOVE;
               1:       fn = FN_POP_FRONT;
               default: fn = FN_POP_BACK;
            endcase
         end
         pos = ($urandom_range(9) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(16));
         send_beat(fn, pos, pick_value());
      end
   endtask

   initial begin : stimulus
      logic signed [15:0] set_lo [6];
      logic signed [15:0] set_hi [6];
      logic signed [15:0] a;
      logic signed [15:0] b;

      reset        = 1'b1;
      req_if.valid = 1'b0;
      req_if.func  = FN_SEARCH;
      req_if.index = '0;
      req_if.value = '0;
      csr_wr_en    = 1'b0;
      csr_index    = CSR_VALUE_MIN;
      csr_wdata    = '0;
      for (int j = 0; j < POOL_SIZE; j++) value_pool[j] = '0;

      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed: empty array, edges of the value field, every operation
      send_idle_pct = 32;
      recv_idle_pct = 46;
      send_beat(FN_POP_FRONT, 5'd0, 16'sd0);
      send_beat(FN_POP_BACK, 5'd0, 16'sd0);
      send_beat(FN_REMOVE, 5'd0, 16'sd0);
      send_beat(FN_READ, 5'd0, 16'sd0);
      send_beat(FN_UPDATE, 5'd0, 16'sd1);
      send_beat(FN_SEARCH, 5'd0, 16'sd0);
      send_beat(FN_PUSH_BACK, 5'd0, 16'sh8000);
      send_beat(FN_PUSH_FRONT, 5'd0, 16'sh7FFF);
      send_beat(FN_INSERT, 5'd1, 16'sd0);
      send_beat(FN_INSERT, 5'd5, 16'sd3);
      send_beat(FN_INSERT, 5'd3, 16'sd7);
      send_beat(FN_READ, 5'd0, 16'sd0);
      send_beat(FN_READ, 5'd3, 16'sd0);
      send_beat(FN_READ, 5'd4, 16'sd0);
      send_beat(FN_READ, 5'd31, 16'sd0);
      send_beat(FN_SEARCH, 5'd0, 16'sd0);
      send_beat(FN_SEARCH, 5'd0, 16'sh8000);
      send_beat(FN_SEARCH, 5'd0, 16'sd1234);
      send_beat(FN_UPDATE, 5'd2, -16'sd1);
      send_beat(FN_UPDATE, 5'd4, 16'sd5);
      send_beat(4'd9, 5'd16, 16'sd9);
      send_beat(4'd15, 5'd31, -16'sd9);
      send_beat(FN_REMOVE, 5'd1, 16'sd0);
      send_beat(FN_REMOVE, 5'd5, 16'sd0);
      send_beat(FN_POP_FRONT, 5'd0, 16'sd0);

      // inverted limits reject every value
      wait_for_drain();
      write_limits(16'sh7FFF, 16'sh8000);
      send_beat(FN_PUSH_BACK, 5'd0, 16'sd0);
      send_beat(FN_SEARCH, 5'd0, 16'sd0);
      send_beat(FN_UPDATE, 5'd0, 16'sd0);
      wait_for_drain();
      write_limits(16'sh8000, 16'sh7FFF);

      // long result hold-off while requests keep coming: fills to full
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_requests++;
      for (int n = 0; n < 40; n++)
         send_beat((n % 3 == 0) ? FN_INSERT : FN_PUSH_BACK, 5'($urandom_range(16)),
                   in_range_value());
      wait_for_drain();

      // limit settings for the random part; slot 1 is redrawn each time
      set_lo = '{16'sh8000, 16'sh8000, 16'sd0, 16'sh7FFF, 16'sh8000, 16'sh7FFF};
      set_hi = '{16'sh7FFF, 16'sh7FFF, 16'sd0, 16'sh8000, 16'sh8000, 16'sh7FFF};

      for (int mode = 0; mode < 3; mode++) begin
         case (mode)
            0:       begin send_idle_pct = 32; recv_idle_pct = 46; end
            1:       begin send_idle_pct = 46; recv_idle_pct = 32; end
            default: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
         endcase
         for (int s = 0; s < 6; s++) begin
            if (s == 1) begin
               a = 16'($urandom());
               b = 16'($urandom());
               set_lo[1] = (a < b) ? a : b;
               set_hi[1] = (a < b) ? b : a;
            end
            wait_for_drain();
            write_limits(set_lo[s], set_hi[s]);
            random_ops(RANDOM_PER_PHASE);
         end
      end

      wait_for_drain();
      repeat (4) @(negedge clock);

      $display("summary: %0d request beats sent, %0d result beats checked, %0d limit settings",
               items_sent, checked_count, limit_writes);
      $display("summary: three idle profiles, a long result hold-off and drain pauses");
      if (mismatch_count == 0 && pending_results == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

[sim.f]
rtl/core/iais_pkg.sv
rtl/core/iais_req_if.sv
rtl/core/iais_rsp_if.sv
rtl/core/iais_cell.sv
rtl/core/iais_row.sv
rtl/core/indexed_array_insert_remove_search_unit.sv
bench/array_result_checker.sv
bench/tb_top.sv
